// File: design/spd_pkg.sv
// shared types, constants and lookup functions for the sky patch index pipeline
package spd_pkg;

  localparam int DIR_WIDTH     = 16;
  localparam int CORDIC_STAGES = 16;

  // cordic datapath: room for the half-turn negation and the cordic gain
  localparam int XY_W  = DIR_WIDTH + 3;
  localparam int ANG_W = 32;
  localparam int CNT_W = 5;
  localparam int PRD_W = ANG_W + CNT_W;

  // z compares run in the finer of Q.(DIR_WIDTH-1) and Q0.24
  localparam int ZFRAC = (DIR_WIDTH - 1 > 24) ? DIR_WIDTH - 1 : 24;
  localparam int CMP_W = ZFRAC + 2;

  localparam logic [7:0] PATCH_ZENITH = 8'd144;
  localparam logic [7:0] PATCH_GND_HI = 8'd145;
  localparam logic [7:0] PATCH_GND_MD = 8'd146;
  localparam logic [7:0] PATCH_GND_LO = 8'd147;
  localparam logic [2:0] BAND_ZENITH  = 3'd7;

  localparam logic [ANG_W-1:0] ANG_HALF = {1'b1, {(ANG_W-1){1'b0}}};

  typedef logic signed [CMP_W-1:0] cmp_t;
  typedef logic signed [XY_W-1:0]  xy_t;
  typedef logic [ANG_W-1:0]        ang_t;

  typedef struct packed {
    logic signed [DIR_WIDTH-1:0] dir_x;
    logic signed [DIR_WIDTH-1:0] dir_y;
    logic signed [DIR_WIDTH-1:0] dir_z;
  } dir_beat_t;

  typedef struct packed {
    logic [7:0] patch_index;
    logic [2:0] band_index;
  } patch_beat_t;

  // results of the z compares, carried alongside the azimuth
  typedef struct packed {
    logic       sky;
    logic [2:0] band;
    logic [7:0] gnd_patch;
  } tag_t;

  typedef struct packed {
    xy_t  x;
    xy_t  y;
    ang_t ang;
    logic hold;
    tag_t tag;
  } cordic_t;

  function automatic logic [7:0] band_base(input logic [2:0] b);
    logic [7:0] r;
    unique case (b)
      3'd0: r = 8'd0;
      3'd1: r = 8'd30;
      3'd2: r = 8'd60;
      3'd3: r = 8'd84;
      3'd4: r = 8'd108;
      3'd5: r = 8'd126;
      3'd6: r = 8'd138;
      3'd7: r = 8'd144;
    endcase
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] band_count(input logic [2:0] b);
    logic [CNT_W-1:0] r;
    unique case (b)
      3'd0: r = CNT_W'(30);
      3'd1: r = CNT_W'(30);
      3'd2: r = CNT_W'(24);
      3'd3: r = CNT_W'(24);
      3'd4: r = CNT_W'(18);
      3'd5: r = CNT_W'(12);
      3'd6: r = CNT_W'(6);
      3'd7: r = CNT_W'(0);
    endcase
    return r;
  endfunction

  // sin(12(k+1) deg) in Q0.24, aligned to the compare format
  function automatic cmp_t band_thr(input logic [2:0] k);
    logic signed [25:0] q;
    unique case (k)
      3'd0:    q = 26'sd3488179;
      3'd1:    q = 26'sd6823909;
      3'd2:    q = 26'sd9861400;
      3'd3:    q = 26'sd12467901;
      3'd4:    q = 26'sd14529495;
      3'd5:    q = 26'sd15956081;
      3'd6:    q = 26'sd16685309;
      default: q = 26'sd0;
    endcase
    return cmp_t'(q) <<< (ZFRAC - 24);
  endfunction

  function automatic cmp_t gnd_thr_low();
    logic signed [25:0] q;
    q = -26'sd2913364;
    return cmp_t'(q) <<< (ZFRAC - 24);
  endfunction

  function automatic cmp_t gnd_thr_half();
    logic signed [25:0] q;
    q = -26'sd8388608;
    return cmp_t'(q) <<< (ZFRAC - 24);
  endfunction

  // atan(2^-i) in units of 2^-32 turn
  function automatic ang_t atan_step(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933405;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335086;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41721;
      5'd15: r = 32'd20860;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2607;
      5'd19: r = 32'd1303;
      5'd20: r = 32'd651;
      5'd21: r = 32'd325;
      5'd22: r = 32'd162;
      5'd23: r = 32'd81;
      5'd24: r = 32'd40;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd2;
      5'd29: r = 32'd1;
      5'd30: r = 32'd0;
      5'd31: r = 32'd0;
    endcase
    return ang_t'(r);
  endfunction

endpackage

// File: design/spd_cordic.sv
// pipelined vectoring cordic, one rotation stage per register
module spd_cordic (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  spd_pkg::cordic_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output spd_pkg::cordic_t out_data
);
  import spd_pkg::*;

  localparam int N = CORDIC_STAGES;

  logic    [N-1:0] v_r;
  logic    [N-1:0] v_nxt;
  logic    [N:0]   en;
  cordic_t         d_r   [N];
  cordic_t         d_nxt [N];

  // a stage loads when empty or when its item moves on
  assign en[N] = !out_stall;

  for (genvar i = 0; i < N; i++) begin : g_stage
    cordic_t src;
    logic    src_v;
    xy_t     xs;
    xy_t     ys;

    if (i == 0) begin : g_head
      assign src   = in_data;
      assign src_v = in_valid;
    end else begin : g_body
      assign src   = d_r[i-1];
      assign src_v = v_r[i-1];
    end

    assign en[i] = !v_r[i] || en[i+1];
    assign xs    = src.x >>> i;
    assign ys    = src.y >>> i;

    always_comb begin
      d_nxt[i] = src;
      if (!src.hold) begin
        if (src.y < 0) begin
          d_nxt[i].x   = src.x - ys;
          d_nxt[i].y   = src.y + xs;
          d_nxt[i].ang = src.ang - atan_step(5'(i));
        end else begin
          d_nxt[i].x   = src.x + ys;
          d_nxt[i].y   = src.y - xs;
          d_nxt[i].ang = src.ang + atan_step(5'(i));
        end
      end
    end

    assign v_nxt[i] = en[i] ? src_v : v_r[i];

    always_ff @(posedge clk) begin
      if (en[i]) begin
        d_r[i] <= d_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v_r[N-1];
  assign out_data  = d_r[N-1];

endmodule

// File: design/sky_patch_index_from_direction.sv
// ray direction to sky patch index, fully pipelined
//
//  port group  dir  handshake          carries
//  in_*        in   in_valid/in_stall  dir_beat_t (dir_x, dir_y, dir_z)
//  out_*       out  out_valid/out_stall patch_beat_t (patch_index, band_index)
//  cfg_*       in   cfg_valid/cfg_ready ground_split bit
//
// one beat per cycle in and out while out_stall is low; beats pass through one
// register per cordic rotation plus prep, multiply and output stages.
// synchronous active-low reset clears all valid bits and sets ground_split to 1.
// each stage holds its beat while the next one is full and stalled; empty stages
// keep filling, so beats are taken behind a stalled result until the pipe is full.
module sky_patch_index_from_direction (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  spd_pkg::dir_beat_t   in_beat,
  output logic                 out_valid,
  input  logic                 out_stall,
  output spd_pkg::patch_beat_t out_beat,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_data
);
  import spd_pkg::*;

  logic        ground_split_r;

  // prep stage
  logic        p_v_r;
  cordic_t     p_r;
  cordic_t     p_nxt;
  logic        p_en;

  // cordic pipeline
  logic        c_in_stall;
  logic        c_v;
  cordic_t     c_d;

  // multiply stage
  logic                 m_v_r;
  logic                 m_en;
  logic [CNT_W-1:0]     m_off_r;
  logic [CNT_W-1:0]     m_off_nxt;
  tag_t                 m_tag_r;
  logic [PRD_W-1:0]     prod;

  // output stage
  logic        o_v_r;
  logic        o_en;
  patch_beat_t o_r;
  patch_beat_t o_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ground_split_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      ground_split_r <= cfg_data;
    end
  end

  // enable chain, output side first
  assign o_en     = !o_v_r || !out_stall;
  assign m_en     = !m_v_r || o_en;
  assign p_en     = !p_v_r || !c_in_stall;
  assign in_stall = !p_en;

  // prep: z compares, half-turn fold, axis special case
  always_comb begin
    xy_t        xw;
    xy_t        yw;
    cmp_t       zc;
    logic [6:0] ge;

    xw = xy_t'(in_beat.dir_x);
    yw = xy_t'(in_beat.dir_y);
    zc = cmp_t'(in_beat.dir_z) <<< (ZFRAC - (DIR_WIDTH - 1));

    for (int k = 0; k < 7; k++) begin
      ge[k] = (zc >= band_thr(3'(k)));
    end

    p_nxt.tag.sky  = (in_beat.dir_z > 0);
    p_nxt.tag.band = 3'($countones(ge));

    priority if (!ground_split_r || zc >= gnd_thr_low()) begin
      p_nxt.tag.gnd_patch = PATCH_GND_HI;
    end else if (zc >= gnd_thr_half()) begin
      p_nxt.tag.gnd_patch = PATCH_GND_MD;
    end else begin
      p_nxt.tag.gnd_patch = PATCH_GND_LO;
    end

    // on the x axis the angle is exact and the cordic passes it through
    p_nxt.hold = (in_beat.dir_y == 0);
    if (xw < 0) begin
      p_nxt.x   = -xw;
      p_nxt.y   = -yw;
      p_nxt.ang = ANG_HALF;
    end else begin
      p_nxt.x   = xw;
      p_nxt.y   = yw;
      p_nxt.ang = '0;
    end
  end

  spd_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (p_v_r),
    .in_stall  (c_in_stall),
    .in_data   (p_r),
    .out_valid (c_v),
    .out_stall (!m_en),
    .out_data  (c_d)
  );

  // patch offset = (angle * count) >> 32
  assign prod      = PRD_W'(c_d.ang) * PRD_W'(band_count(c_d.tag.band));
  assign m_off_nxt = prod[PRD_W-1:ANG_W];

  always_comb begin
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] off;
    cnt = band_count(m_tag_r.band);
    off = m_off_r;
    if (cnt != '0 && off > cnt - CNT_W'(1)) begin
      off = cnt - CNT_W'(1);
    end
    if (!m_tag_r.sky) begin
      o_nxt.patch_index = m_tag_r.gnd_patch;
      o_nxt.band_index  = '0;
    end else if (m_tag_r.band == BAND_ZENITH) begin
      o_nxt.patch_index = PATCH_ZENITH;
      o_nxt.band_index  = m_tag_r.band;
    end else begin
      o_nxt.patch_index = band_base(m_tag_r.band) + 8'(off);
      o_nxt.band_index  = m_tag_r.band;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
      m_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (p_en) begin
        p_v_r <= in_valid;
      end
      if (m_en) begin
        m_v_r <= c_v;
      end
      if (o_en) begin
        o_v_r <= m_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p_en) begin
      p_r <= p_nxt;
    end
    if (m_en) begin
      m_off_r <= m_off_nxt;
      m_tag_r <= c_d.tag;
    end
    if (o_en) begin
      o_r <= o_nxt;
    end
  end

  assign out_valid = o_v_r;
  assign out_beat  = o_r;

  a_zenith: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.band_index == BAND_ZENITH |-> out_beat.patch_index == PATCH_ZENITH)
    else $error("zenith band without zenith patch");

  a_ground_band: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.patch_index >= PATCH_GND_HI |-> out_beat.band_index == '0)
    else $error("ground patch with nonzero band");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_beat.patch_index <= PATCH_GND_LO)
    else $error("patch index out of range");

  a_in_band: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.patch_index < PATCH_ZENITH |->
      out_beat.patch_index >= band_base(out_beat.band_index) &&
      out_beat.patch_index < band_base(out_beat.band_index)
                             + 8'(band_count(out_beat.band_index)))
    else $error("sky patch outside its band");

  a_prep_hold: assert property (@(posedge clk) disable iff (!rst_n)
    p_v_r && !p_en |=> p_v_r && $stable(p_r))
    else $error("blocked prep beat lost");

endmodule
